>>> design/tpd_pkg.sv
// Shared types and constants of the two-priority task dispatcher.
package tpd_pkg;

	localparam int CMD_W    = 2;
	localparam int CLASS_W  = 2;
	localparam int TASK_W   = 8;
	localparam int WORKER_W = 4;
	localparam int STATUS_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD_TASK = 2'd0,
		CMD_AVAIL    = 2'd1,
		CMD_REGISTER = 2'd2
	} cmd_code_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_STARTED = 2'd0,
		ST_QUEUED  = 2'd1,
		ST_PARKED  = 2'd2,
		ST_DROPPED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_POP_IDLE,
		ACT_POP_HIGH,
		ACT_POP_LOW,
		ACT_PUSH_IDLE,
		ACT_PUSH_HIGH,
		ACT_PUSH_LOW
	} act_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_RESP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic    load;
		logic    exec;
		act_t    act;
		status_t status;
		logic    capture;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             low;
		logic             cls_ok;
		logic             worker_ok;
		logic             idle_empty;
		logic             idle_full;
		logic             high_empty;
		logic             high_full;
		logic             low_empty;
		logic             low_full;
	} dp_stat_t;

endpackage

>>> design/tpd_queue.sv
// Bank of per-class circular FIFOs sharing one memory, with registered read data.
module tpd_queue #(
	parameter int NUM_CLASSES = 4,
	parameter int QUEUE_DEPTH = 16,
	parameter int DW          = 8,
	parameter int CLS_W       = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CLS_W-1:0] cls,
	input  logic             push,
	input  logic             pop,
	input  logic [DW-1:0]    wdata,
	output logic [DW-1:0]    rdata,
	output logic             empty,
	output logic             full
);
	localparam int PW   = $clog2(QUEUE_DEPTH);
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
	localparam int ENT  = NUM_CLASSES * QUEUE_DEPTH;
	localparam int AW   = (ENT > 1) ? $clog2(ENT) : 1;

	logic [PW-1:0]   head_q  [NUM_CLASSES];
	logic [PW-1:0]   tail_q  [NUM_CLASSES];
	logic [CNTW-1:0] count_q [NUM_CLASSES];
	logic [DW-1:0]   mem     [ENT];
	logic [DW-1:0]   rdata_q;
	logic [AW-1:0]   waddr;
	logic [AW-1:0]   raddr;
	logic [PW-1:0]   head_nxt;
	logic [PW-1:0]   tail_nxt;

	assign empty = (count_q[cls] == '0);
	assign full  = (count_q[cls] == CNTW'(QUEUE_DEPTH));

	assign waddr = AW'(cls) * AW'(QUEUE_DEPTH) + AW'(tail_q[cls]);
	assign raddr = AW'(cls) * AW'(QUEUE_DEPTH) + AW'(head_q[cls]);

	// pointers wrap at the depth, which need not be a power of two
	assign head_nxt = (head_q[cls] == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q[cls] + 1'b1;
	assign tail_nxt = (tail_q[cls] == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_q[cls] + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (push) begin
			tail_q[cls]  <= tail_nxt;
			count_q[cls] <= count_q[cls] + 1'b1;
		end else if (pop) begin
			head_q[cls]  <= head_nxt;
			count_q[cls] <= count_q[cls] - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[waddr] <= wdata;
		end
		if (pop) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

`ifndef SYNTH
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && pop)) else $error("push and pop in the same cycle");
`endif
endmodule

>>> design/tpd_datapath.sv
// Datapath: request registers, the three queue banks and the result registers.
module tpd_datapath #(
	parameter int NUM_CLASSES  = 4,
	parameter int QUEUE_DEPTH  = 16,
	parameter int NUM_WORKERS  = 16,
	parameter int TASK_ID_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tpd_pkg::ctrl_cmd_t  ctl,
	output tpd_pkg::dp_stat_t   stat,
	input  logic [tpd_pkg::CMD_W-1:0]    command,
	input  logic [tpd_pkg::CLASS_W-1:0]  class_id,
	input  logic [tpd_pkg::TASK_W-1:0]   task_id,
	input  logic                         low_prio,
	input  logic [tpd_pkg::WORKER_W-1:0] worker_id,
	output logic [tpd_pkg::STATUS_W-1:0] status,
	output logic [tpd_pkg::WORKER_W-1:0] started_worker,
	output logic [tpd_pkg::TASK_W-1:0]   started_task,
	output logic [tpd_pkg::CLASS_W-1:0]  result_class
);
	import tpd_pkg::*;

	localparam int TW    = (TASK_ID_BITS < TASK_W) ? TASK_ID_BITS : TASK_W;
	localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

	logic [CMD_W-1:0]    cmd_q;
	logic [CLASS_W-1:0]  class_q;
	logic [TW-1:0]       task_q;
	logic                low_q;
	logic [WORKER_W-1:0] worker_q;
	logic                cls_ok_q;
	logic                worker_ok_q;
	act_t                act_q;

	logic [STATUS_W-1:0] res_status_q;
	logic [WORKER_W-1:0] res_worker_q;
	logic [TW-1:0]       res_task_q;

	logic [CLS_W-1:0]    cls;
	logic [WORKER_W-1:0] idle_rd;
	logic [TW-1:0]       high_rd;
	logic [TW-1:0]       low_rd;
	logic                idle_empty, idle_full;
	logic                high_empty, high_full;
	logic                low_empty, low_full;

	assign cls = CLS_W'(class_q);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q       <= command;
			class_q     <= class_id;
			task_q      <= task_id[TW-1:0];
			low_q       <= low_prio;
			worker_q    <= worker_id;
			cls_ok_q    <= (int'(class_id) < NUM_CLASSES);
			worker_ok_q <= (int'(worker_id) < NUM_WORKERS);
		end
		if (ctl.exec) begin
			act_q        <= ctl.act;
			res_status_q <= ctl.status;
			res_worker_q <= '0;
			res_task_q   <= '0;
		end
		if (ctl.capture) begin
			case (act_q)
				ACT_POP_IDLE: begin
					res_worker_q <= idle_rd;
					res_task_q   <= task_q;
				end
				ACT_POP_HIGH: begin
					res_worker_q <= worker_q;
					res_task_q   <= high_rd;
				end
				ACT_POP_LOW: begin
					res_worker_q <= worker_q;
					res_task_q   <= low_rd;
				end
				default: begin
					res_worker_q <= '0;
					res_task_q   <= '0;
				end
			endcase
		end
	end

	tpd_queue #(
		.NUM_CLASSES(NUM_CLASSES), .QUEUE_DEPTH(QUEUE_DEPTH), .DW(WORKER_W), .CLS_W(CLS_W)
	) u_idle (
		.clk   (clk),
		.arst_n(arst_n),
		.cls   (cls),
		.push  (ctl.exec && ctl.act == ACT_PUSH_IDLE),
		.pop   (ctl.exec && ctl.act == ACT_POP_IDLE),
		.wdata (worker_q),
		.rdata (idle_rd),
		.empty (idle_empty),
		.full  (idle_full)
	);

	tpd_queue #(
		.NUM_CLASSES(NUM_CLASSES), .QUEUE_DEPTH(QUEUE_DEPTH), .DW(TW), .CLS_W(CLS_W)
	) u_high (
		.clk   (clk),
		.arst_n(arst_n),
		.cls   (cls),
		.push  (ctl.exec && ctl.act == ACT_PUSH_HIGH),
		.pop   (ctl.exec && ctl.act == ACT_POP_HIGH),
		.wdata (task_q),
		.rdata (high_rd),
		.empty (high_empty),
		.full  (high_full)
	);

	tpd_queue #(
		.NUM_CLASSES(NUM_CLASSES), .QUEUE_DEPTH(QUEUE_DEPTH), .DW(TW), .CLS_W(CLS_W)
	) u_low (
		.clk   (clk),
		.arst_n(arst_n),
		.cls   (cls),
		.push  (ctl.exec && ctl.act == ACT_PUSH_LOW),
		.pop   (ctl.exec && ctl.act == ACT_POP_LOW),
		.wdata (task_q),
		.rdata (low_rd),
		.empty (low_empty),
		.full  (low_full)
	);

	always_comb begin
		stat.cmd        = cmd_q;
		stat.low        = low_q;
		stat.cls_ok     = cls_ok_q;
		stat.worker_ok  = worker_ok_q;
		stat.idle_empty = idle_empty;
		stat.idle_full  = idle_full;
		stat.high_empty = high_empty;
		stat.high_full  = high_full;
		stat.low_empty  = low_empty;
		stat.low_full   = low_full;
	end

	assign status         = res_status_q;
	assign started_worker = res_worker_q;
	assign started_task   = TASK_W'(res_task_q);
	assign result_class   = class_q;
endmodule

>>> design/tpd_ctrl.sv
// Controller: request sequencing and the dispatch decision for each command.
module tpd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	output logic               res_valid,
	input  logic               res_stall,
	input  tpd_pkg::dp_stat_t  stat,
	output tpd_pkg::ctrl_cmd_t ctl
);
	import tpd_pkg::*;

	state_t  state_q;
	state_t  state_nxt;
	act_t    act;
	status_t st;

	// dispatch decision, from the flags of the addressed class
	always_comb begin
		act = ACT_NONE;
		st  = ST_DROPPED;
		if (stat.cls_ok) begin
			case (cmd_code_t'(stat.cmd))
				CMD_ADD_TASK: begin
					if (!stat.idle_empty) begin
						act = ACT_POP_IDLE;
						st  = ST_STARTED;
					end else if (stat.low) begin
						if (!stat.low_full) begin
							act = ACT_PUSH_LOW;
							st  = ST_QUEUED;
						end
					end else if (!stat.high_full) begin
						act = ACT_PUSH_HIGH;
						st  = ST_QUEUED;
					end
				end
				CMD_AVAIL: begin
					if (stat.worker_ok) begin
						if (!stat.high_empty) begin
							act = ACT_POP_HIGH;
							st  = ST_STARTED;
						end else if (!stat.low_empty) begin
							act = ACT_POP_LOW;
							st  = ST_STARTED;
						end else if (!stat.idle_full) begin
							act = ACT_PUSH_IDLE;
							st  = ST_PARKED;
						end
					end
				end
				CMD_REGISTER: begin
					if (stat.worker_ok && !stat.idle_full) begin
						act = ACT_PUSH_IDLE;
						st  = ST_PARKED;
					end
				end
				default: begin
					act = ACT_NONE;
					st  = ST_DROPPED;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt   = state_q;
		ctl.load    = 1'b0;
		ctl.exec    = 1'b0;
		ctl.act     = act;
		ctl.status  = st;
		ctl.capture = 1'b0;
		cmd_stall   = 1'b1;
		res_valid   = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					ctl.load  = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.exec = 1'b1;
				// pops go through S_READ to wait for the registered read data
				if (act inside {ACT_POP_IDLE, ACT_POP_HIGH, ACT_POP_LOW}) begin
					state_nxt = S_READ;
				end else begin
					state_nxt = S_RESP;
				end
			end
			S_READ: begin
				ctl.capture = 1'b1;
				state_nxt   = S_RESP;
			end
			S_RESP: begin
				res_valid = 1'b1;
				if (!res_stall) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

`ifndef SYNTH
	a_pop_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && (act == ACT_POP_IDLE || act == ACT_POP_HIGH ||
		act == ACT_POP_LOW)) |=> state_q == S_READ)
		else $error("pop did not wait for read data");
	a_push_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && !(act == ACT_POP_IDLE || act == ACT_POP_HIGH ||
		act == ACT_POP_LOW)) |=> state_q == S_RESP)
		else $error("non-pop command did not go to response");
	a_read_resp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |=> state_q == S_RESP)
		else $error("read cycle not followed by response");
`endif
endmodule

>>> design/two_priority_task_dispatcher.sv
// Top level of the two-priority task dispatcher.
// Usage:
//   Command channel (cmd_valid/cmd_stall) carries one request: add a task,
//   announce an available worker, or register a worker, for one class.
//   Result channel (res_valid/res_stall) returns exactly one status per
//   request, with the started worker and task when a task starts.
//   Each class has an idle-worker FIFO and high/low task FIFOs, all
//   QUEUE_DEPTH deep, kept in one shared memory per FIFO kind.
// Timing:
//   One request is handled at a time. After acceptance the sequencer runs
//   S_EXEC, then S_READ when a FIFO is popped (the memory read is
//   registered), then S_RESP, where the result is valid. A new request is
//   taken the cycle after its result is taken, never while one is in flight.
// Reset:
//   arst_n clears all FIFO pointers and counts (every FIFO empty) and the
//   sequencer; FIFO contents are not cleared and no sweep is needed.
// Stall:
//   While res_stall is high the result holds and cmd_stall stays high.
module two_priority_task_dispatcher #(
	parameter int NUM_CLASSES  = 4,
	parameter int QUEUE_DEPTH  = 16,
	parameter int NUM_WORKERS  = 16,
	parameter int TASK_ID_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_stall,
	input  logic [tpd_pkg::CMD_W-1:0]    command,
	input  logic [tpd_pkg::CLASS_W-1:0]  class_id,
	input  logic [tpd_pkg::TASK_W-1:0]   task_id,
	input  logic                         low_prio,
	input  logic [tpd_pkg::WORKER_W-1:0] worker_id,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [tpd_pkg::STATUS_W-1:0] status,
	output logic [tpd_pkg::WORKER_W-1:0] started_worker,
	output logic [tpd_pkg::TASK_W-1:0]   started_task,
	output logic [tpd_pkg::CLASS_W-1:0]  result_class
);
	import tpd_pkg::*;

	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	tpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	tpd_datapath #(
		.NUM_CLASSES (NUM_CLASSES),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.NUM_WORKERS (NUM_WORKERS),
		.TASK_ID_BITS(TASK_ID_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.command       (command),
		.class_id      (class_id),
		.task_id       (task_id),
		.low_prio      (low_prio),
		.worker_id     (worker_id),
		.status        (status),
		.started_worker(started_worker),
		.started_task  (started_task),
		.result_class  (result_class)
	);
endmodule
